@@ hdl/vec4_matrix_transform_macros.svh @@
// Assertion macros shared by the vec4 matrix transform RTL.
`ifndef VEC4_MATRIX_TRANSFORM_MACROS_SVH
`define VEC4_MATRIX_TRANSFORM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vmt assertion failed");

// Next-cycle implication, checked outside reset.
`define VMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vmt assertion failed");

`endif

@@ hdl/vmt_pkg.sv @@
// Types and constants of the vec4 matrix transform block.
package vmt_pkg;

    localparam int FracBits = 16;
    localparam int CompW    = 32;
    localparam int ProdW    = 2 * CompW;
    localparam int PairW    = ProdW + 1;
    localparam int SumW     = ProdW + 2;
    localparam int RegW     = 64;
    localparam int NumRegs  = 8;
    localparam int MatIdxW  = $clog2(NumRegs);
    localparam int CfgIdxW  = MatIdxW + 1;
    localparam int Dim      = 4;

    // Identity matrix, two Q16.16 entries per register.
    localparam logic [RegW-1:0] MatReset [NumRegs] = '{
        64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
    };

    localparam logic signed [CompW-1:0] CompMax = {1'b0, {(CompW-1){1'b1}}};
    localparam logic signed [CompW-1:0] CompMin = {1'b1, {(CompW-1){1'b0}}};

    typedef enum logic {
        OP_ROW_VEC = 1'b0,   // row vector times matrix
        OP_COL_VEC = 1'b1    // matrix times column vector
    } t_vmt_op;

    typedef struct packed {
        t_vmt_op                  opcode;
        logic signed [CompW-1:0]  in_x;
        logic signed [CompW-1:0]  in_y;
        logic signed [CompW-1:0]  in_z;
        logic signed [CompW-1:0]  in_w;
    } t_vmt_in;

    typedef struct packed {
        logic signed [CompW-1:0]  out_x;
        logic signed [CompW-1:0]  out_y;
        logic signed [CompW-1:0]  out_z;
        logic signed [CompW-1:0]  out_w;
        logic                     clipped;
    } t_vmt_out;

endpackage

@@ hdl/vec4_matrix_transform.sv @@
// Vec4 matrix transform: five-stage pipelined 4x4 matrix-vector product, Q16.16.
// Throughput: one item per cycle unless the output stalls; 16 parallel 32x32
// multipliers in one stage, then two adder stages and a shift/saturate stage, each
// registered. Stages advance independently, so bubbles collapse under output stall.
// Reset (sync, active low) clears all valid bits and loads the identity matrix.
`include "vec4_matrix_transform_macros.svh"

module vec4_matrix_transform
    import vmt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_vmt_in             i_in_data,
    // result item channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_vmt_out            o_out_data,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [RegW-1:0]     i_cfg_data
);

    // ---------------------------------------------------------------
    // Matrix registers
    // ---------------------------------------------------------------
    logic [RegW-1:0] r_mat [NumRegs];
    logic            cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready && (i_cfg_index < CfgIdxW'(NumRegs));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumRegs; i++) begin
                r_mat[i] <= MatReset[i];
            end
        end else if (cfg_wr) begin
            r_mat[i_cfg_index[MatIdxW-1:0]] <= i_cfg_data;
        end
    end

    // Unpack to m[row][col]: register 2r + c/2, low half for even columns.
    logic signed [CompW-1:0] mat [Dim][Dim];

    always_comb begin
        for (int r = 0; r < Dim; r++) begin
            for (int c = 0; c < Dim; c++) begin
                mat[r][c] = r_mat[r*2 + c/2][(c%2)*CompW +: CompW];
            end
        end
    end

    // ---------------------------------------------------------------
    // Per-stage valid bits and advance conditions
    // ---------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // A stage loads when it is empty or its contents move on.
    assign rdy5 = !r_v5 || !i_out_stall;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_in_stall  = !rdy1;
    assign o_out_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: vector and opcode-selected coefficients
    //   out[k] = sum_i v[i] * coef[k][i]
    //   row-vector form uses column k, column-vector form uses row k
    // ---------------------------------------------------------------
    logic signed [CompW-1:0] n_vec  [Dim];
    logic signed [CompW-1:0] n_coef [Dim][Dim];
    logic signed [CompW-1:0] r_vec  [Dim];
    logic signed [CompW-1:0] r_coef [Dim][Dim];

    always_comb begin
        n_vec[0] = i_in_data.in_x;
        n_vec[1] = i_in_data.in_y;
        n_vec[2] = i_in_data.in_z;
        n_vec[3] = i_in_data.in_w;
        for (int k = 0; k < Dim; k++) begin
            for (int i = 0; i < Dim; i++) begin
                n_coef[k][i] = (i_in_data.opcode == OP_COL_VEC) ? mat[k][i] : mat[i][k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: sixteen full-precision products
    // Stage 3: pairwise sums
    // Stage 4: four-term sums, exact
    // ---------------------------------------------------------------
    logic signed [ProdW-1:0] r_prod [Dim][Dim];
    logic signed [PairW-1:0] r_pair [Dim][2];
    logic signed [SumW-1:0]  r_sum  [Dim];

    // Stage 5: shift down by the fraction bits and saturate.
    logic signed [SumW-1:0]  shifted [Dim];
    logic signed [CompW-1:0] n_comp  [Dim];
    logic [Dim-1:0]          n_sat;
    t_vmt_out                n_out;
    t_vmt_out                r_out;

    always_comb begin
        for (int k = 0; k < Dim; k++) begin
            shifted[k] = r_sum[k] >>> FracBits;
            // fits when every bit from the sign of a 32-bit value upward agrees
            n_sat[k] = !((&shifted[k][SumW-1:CompW-1]) || !(|shifted[k][SumW-1:CompW-1]));
            if (!n_sat[k]) begin
                n_comp[k] = shifted[k][CompW-1:0];
            end else if (shifted[k][SumW-1]) begin
                n_comp[k] = CompMin;
            end else begin
                n_comp[k] = CompMax;
            end
        end
        n_out.out_x   = n_comp[0];
        n_out.out_y   = n_comp[1];
        n_out.out_z   = n_comp[2];
        n_out.out_w   = n_comp[3];
        n_out.clipped = |n_sat;
    end

    // Payload registers: no reset, enabled by each stage's advance.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && rdy1) begin
            r_vec  <= n_vec;
            r_coef <= n_coef;
        end
        if (r_v1 && rdy2) begin
            for (int k = 0; k < Dim; k++) begin
                for (int i = 0; i < Dim; i++) begin
                    r_prod[k][i] <= r_vec[i] * r_coef[k][i];
                end
            end
        end
        if (r_v2 && rdy3) begin
            for (int k = 0; k < Dim; k++) begin
                r_pair[k][0] <= PairW'(r_prod[k][0]) + PairW'(r_prod[k][1]);
                r_pair[k][1] <= PairW'(r_prod[k][2]) + PairW'(r_prod[k][3]);
            end
        end
        if (r_v3 && rdy4) begin
            for (int k = 0; k < Dim; k++) begin
                r_sum[k] <= SumW'(r_pair[k][0]) + SumW'(r_pair[k][1]);
            end
        end
        if (r_v4 && rdy5) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // An accepted item always lands in stage 1.
    `VMT_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_v1)
    // A full pipeline under output stall must push back on the input.
    `VMT_ASSERT_NOW(a_full_stalls, i_clk, i_rst_n,
        r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_out_stall, o_in_stall)
    // A clipped result carries at least one component at a rail.
    `VMT_ASSERT_NOW(a_clip_rail, i_clk, i_rst_n, o_out_valid && o_out_data.clipped,
        o_out_data.out_x == CompMax || o_out_data.out_x == CompMin ||
        o_out_data.out_y == CompMax || o_out_data.out_y == CompMin ||
        o_out_data.out_z == CompMax || o_out_data.out_z == CompMin ||
        o_out_data.out_w == CompMax || o_out_data.out_w == CompMin)
    // A write to register 0 takes effect on the next edge.
    `VMT_ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n,
        i_cfg_valid && o_cfg_ready && i_cfg_index == '0, r_mat[0] == $past(i_cfg_data))

endmodule

@@ bench/vmt_scoreboard_pkg.sv @@
// Scoreboard for the vec4 matrix transform: matrix shadow, Q16.16 transform, result check.
`timescale 1ns / 100ps

package vmt_bench_pkg;

    import vmt_pkg::*;

    class vmt_scoreboard;

        logic [RegW-1:0] mat_shadow [NumRegs];
        t_vmt_out        pending_vecs [$];
        int unsigned     n_vectors;
        int unsigned     n_results;
        int unsigned     n_clipped;
        int unsigned     n_errors;

        function new();
            foreach (mat_shadow[i]) mat_shadow[i] = MatReset[i];
            n_vectors = 0;
            n_results = 0;
            n_clipped = 0;
            n_errors  = 0;
        endfunction

        // Unmapped indexes are dropped, same as the block.
        function void write_reg(int unsigned idx, logic [RegW-1:0] val);
            if (idx < NumRegs) mat_shadow[idx] = val;
        endfunction

        // m[r][c]: register 2r + c/2, even column in the low half.
        function logic signed [CompW-1:0] mat_entry(int r, int c);
            logic [RegW-1:0] w;
            w = mat_shadow[2 * r + c / 2];
            if (c % 2) return w[RegW-1:CompW];
            else       return w[CompW-1:0];
        endfunction

        function t_vmt_out transform_vec(t_vmt_in item);
            logic signed [CompW-1:0] v   [Dim];
            logic signed [CompW-1:0] res [Dim];
            logic signed [CompW-1:0] m;
            logic signed [SumW-1:0]  acc;
            logic                    clip;
            t_vmt_out                o;
            v[0] = item.in_x;
            v[1] = item.in_y;
            v[2] = item.in_z;
            v[3] = item.in_w;
            clip = 1'b0;
            for (int k = 0; k < Dim; k++) begin
                acc = '0;
                for (int i = 0; i < Dim; i++) begin
                    // column k for the row form, row k for the column form
                    m   = (item.opcode == OP_COL_VEC) ? mat_entry(k, i) : mat_entry(i, k);
                    acc = acc + v[i] * m;
                end
                acc = acc >>> FracBits;
                // in range when the bits above the 32-bit sign all match it
                if (acc[SumW-1:CompW-1] == '0 || acc[SumW-1:CompW-1] == '1) begin
                    res[k] = acc[CompW-1:0];
                end else begin
                    res[k] = acc[SumW-1] ? CompMin : CompMax;
                    clip   = 1'b1;
                end
            end
            o.out_x   = res[0];
            o.out_y   = res[1];
            o.out_z   = res[2];
            o.out_w   = res[3];
            o.clipped = clip;
            return o;
        endfunction

        function void note_vector(t_vmt_in item);
            pending_vecs.push_back(transform_vec(item));
            n_vectors++;
        endfunction

        function void check_result(t_vmt_out got);
            t_vmt_out want;
            n_results++;
            if (pending_vecs.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: x=%h y=%h z=%h w=%h clip=%b",
                             got.out_x, got.out_y, got.out_z, got.out_w, got.clipped);
                return;
            end
            want = pending_vecs.pop_front();
            if (want.clipped) n_clipped++;
            if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                got.out_z !== want.out_z || got.out_w !== want.out_w ||
                got.clipped !== want.clipped) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("result %0d wrong: expected x=%h y=%h z=%h w=%h clip=%b",
                             n_results, want.out_x, want.out_y, want.out_z, want.out_w,
                             want.clipped);
                    $display("               got      x=%h y=%h z=%h w=%h clip=%b",
                             got.out_x, got.out_y, got.out_z, got.out_w, got.clipped);
                end
            end
        endfunction

        function int unsigned outstanding();
            return pending_vecs.size();
        endfunction

    endclass

endpackage

@@ bench/tb.sv @@
// Top-level bench for vec4_matrix_transform: directed and random vectors over many matrices.
`timescale 1ns / 100ps

module tb;

    import vmt_pkg::*;
    import vmt_bench_pkg::*;

    localparam int ClkHalf       = 6;
    localparam int Latency       = 5;        // input accept edge to result edge, no stall
    localparam int CycleLimit    = 200000;   // watchdog limit for the whole run
    localparam int NumPhases     = 10;
    localparam int ItemsPerPhase = 115;

    localparam logic signed [CompW-1:0] QOne = 32'sh0001_0000;   // 1.0 in Q16.16

    // How a random matrix is filled
    typedef enum int {
        MAT_SMALL,     // entries within +-4.0
        MAT_FULL,      // raw 32-bit noise, nearly everything clips
        MAT_MIXED,     // per-entry mix of extremes, unit values and noise
        MAT_SPARSE     // mostly zero with unit and extreme entries
    } t_mat_style;

    typedef struct {
        int unsigned     idx;
        logic [RegW-1:0] val;
    } t_cfg_write;

    // ---------------------------------------------------------------
    // Block signals; every input starts at a known value
    // ---------------------------------------------------------------
    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    t_vmt_in            in_data   = '0;
    logic               out_stall = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [RegW-1:0]    cfg_data  = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    t_vmt_out           o_out_data;
    logic               o_cfg_ready;

    vmt_scoreboard      sb;
    t_cfg_write         cfg_q [$];
    logic [RegW-1:0]    mat_next [NumRegs];
    bit                 in_burst;        // sender runs without gaps while set
    int unsigned        cycles     = 0;
    int unsigned        n_settings = 0;
    int unsigned        n_cfg      = 0;
    int unsigned        n_unmapped = 0;

    vec4_matrix_transform i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #(ClkHalf) i_clk = 1'b1;
        #(ClkHalf) i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycles, sb.outstanding());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Value generators
    // ---------------------------------------------------------------

    // Vector component: extremes, zero, +-1.0, raw noise, modest magnitudes.
    function automatic logic signed [CompW-1:0] rand_comp();
        logic [CompW-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return CompMax;
            1:       return CompMin;
            2:       return '0;
            3:       return r[0] ? QOne : -QOne;
            4, 5:    return r;
            default: return $signed(r) >>> $urandom_range(8, 18);
        endcase
    endfunction

    function automatic logic signed [CompW-1:0] rand_entry(t_mat_style style);
        logic [CompW-1:0] r;
        r = $urandom;
        case (style)
            MAT_SMALL: return $signed(r) >>> 13;
            MAT_FULL:  return r;
            MAT_MIXED: return rand_comp();
            default: begin
                case ($urandom_range(0, 7))
                    0:       return QOne;
                    1:       return -QOne;
                    2:       return CompMax;
                    3:       return CompMin;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Drivers; every task is entered and left at a rising edge
    // ---------------------------------------------------------------

    // Block is idle once all results are back; the extra cycles are margin.
    // Valid drops first so the last item is not taken again.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (Latency) @(posedge i_clk);
    endtask

    // Writes go back to back; valid drops only after the last one.
    task automatic flush_cfg();
        t_cfg_write w;
        while (cfg_q.size() > 0) begin
            w = cfg_q.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx[CfgIdxW-1:0];
            cfg_data  <= w.val;
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            sb.write_reg(w.idx, w.val);
            n_cfg++;
        end
        cfg_valid <= 1'b0;
    endtask

    // Load mat_next into all eight registers, then n_bad writes to unmapped
    // indexes; those come last so an aliased index would corrupt the matrix.
    task automatic apply_matrix(int unsigned n_bad);
        t_cfg_write w;
        wait_idle();
        for (int i = 0; i < NumRegs; i++) begin
            w.idx = i;
            w.val = mat_next[i];
            cfg_q.push_back(w);
        end
        repeat (n_bad) begin
            w.idx = $urandom_range(NumRegs, (1 << CfgIdxW) - 1);
            w.val = {$urandom, $urandom};
            cfg_q.push_back(w);
            n_unmapped++;
        end
        flush_cfg();
        n_settings++;
    endtask

    // Idle gap first, then hold the item until the block takes it.
    task automatic send_vec(t_vmt_op op, logic signed [CompW-1:0] x,
                            logic signed [CompW-1:0] y, logic signed [CompW-1:0] z,
                            logic signed [CompW-1:0] w);
        int unsigned gap;
        t_vmt_in     item;
        item.opcode = op;
        item.in_x   = x;
        item.in_y   = y;
        item.in_z   = z;
        item.in_w   = w;
        if ($urandom_range(0, 49) == 0) in_burst = ~in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 11);
        // with no gap valid stays high, so it gets exactly one assignment here
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_vector(item);
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall before each item, then take it
    // ---------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold;
        bit          out_burst;
        out_burst = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
            hold = out_burst ? 0 : $urandom_range(0, 11);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_result(o_out_data);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        logic signed [CompW-1:0] e;
        t_mat_style              style;
        sb       = new();
        in_burst = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset matrix is the identity: components come straight through.
        send_vec(OP_ROW_VEC, '0, '0, '0, '0);
        send_vec(OP_COL_VEC, CompMax, CompMax, CompMax, CompMax);
        send_vec(OP_ROW_VEC, CompMin, CompMin, CompMin, CompMin);
        send_vec(OP_COL_VEC, QOne, -QOne, 32'sh0000_8000, CompMax);

        // Every entry at the negative extreme: both clip directions, and a
        // case where huge products cancel back into range.
        foreach (mat_next[i]) mat_next[i] = {2{CompMin}};
        apply_matrix(0);
        send_vec(OP_ROW_VEC, CompMax, CompMax, CompMax, CompMax);
        send_vec(OP_COL_VEC, CompMin, CompMin, CompMin, CompMin);
        send_vec(OP_ROW_VEC, CompMax, CompMin, '0, '0);

        // Every entry one LSB below zero: the shift rounds toward minus infinity.
        foreach (mat_next[i]) mat_next[i] = '1;
        apply_matrix(0);
        send_vec(OP_COL_VEC, 32'sd1, '0, '0, '0);
        send_vec(OP_ROW_VEC, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
        send_vec(OP_ROW_VEC, -32'sd1, -32'sd1, -32'sd1, -32'sd1);

        // Every entry at the positive extreme.
        foreach (mat_next[i]) mat_next[i] = {2{CompMax}};
        apply_matrix(0);
        send_vec(OP_ROW_VEC, CompMax, CompMax, CompMax, CompMax);
        send_vec(OP_COL_VEC, CompMin, CompMin, CompMin, CompMin);

        // Distinct signed entries so rows and columns cannot be confused.
        for (int r = 0; r < Dim; r++) begin
            for (int c = 0; c < Dim; c++) begin
                e = QOne * (r * Dim + c + 1);
                if ((r + c) % 2) e = -e;
                if (c % 2) mat_next[2 * r + c / 2][RegW-1:CompW] = e;
                else       mat_next[2 * r + c / 2][CompW-1:0]    = e;
            end
        end
        apply_matrix(0);
        send_vec(OP_ROW_VEC, QOne, 2 * QOne, 3 * QOne, 4 * QOne);
        send_vec(OP_COL_VEC, QOne, 2 * QOne, 3 * QOne, 4 * QOne);

        // Same matrix, then junk to unmapped indexes: results must not move.
        apply_matrix(4);
        send_vec(OP_ROW_VEC, QOne, 2 * QOne, 3 * QOne, 4 * QOne);
        send_vec(OP_COL_VEC, -QOne, 32'sh0000_8000, '0, CompMax);

        // Random phases, each on a fresh matrix.
        for (int p = 0; p < NumPhases; p++) begin
            style = t_mat_style'(p % 4);
            if (p == 0) begin
                foreach (mat_next[i]) mat_next[i] = MatReset[i];
            end else begin
                foreach (mat_next[i]) mat_next[i] = {rand_entry(style), rand_entry(style)};
            end
            apply_matrix(($urandom_range(0, 2) == 0) ? 1 : 0);
            repeat (ItemsPerPhase) begin
                send_vec(t_vmt_op'($urandom_range(0, 1)),
                         rand_comp(), rand_comp(), rand_comp(), rand_comp());
            end
        end
        in_valid <= 1'b0;

        // Drain, then give stray results a chance to show up.
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (Latency + 8) @(posedge i_clk);

        $display("%0d vectors in, %0d results checked (%0d clipped), %0d matrix settings",
                 sb.n_vectors, sb.n_results, sb.n_clipped, n_settings);
        $display("%0d register writes (%0d unmapped), %0d mismatches, %0d left over",
                 n_cfg, n_unmapped, sb.n_errors, sb.outstanding());
        if (sb.n_errors == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ vec4_matrix_transform.f @@
+incdir+hdl
hdl/vmt_pkg.sv
hdl/vec4_matrix_transform.sv
bench/vmt_scoreboard_pkg.sv
bench/tb.sv
